[rtl/console_bank_mapper_irq_macros.svh]
// ----------------------------------------------------------------------------
// console_bank_mapper_irq assertion macros
// Shared concurrent assertion shorthands for the bank mapper RTL.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_BANK_MAPPER_IRQ_MACROS_SVH
`define CONSOLE_BANK_MAPPER_IRQ_MACROS_SVH

// same-cycle implication, masked during reset
`define CBM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define CBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, register indexes, decode codes and reset values of the bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam int SLOT_COUNT = 12;
    localparam int PRG_SLOTS  = 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int REG_DEPTH  = 256;
    localparam int REG_AW     = $clog2(REG_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_PRG    = 2'd0,
        KIND_CHR    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [1:0] CFG_PRG_BASE = 2'd1;
    localparam logic [1:0] CFG_CHR_MASK = 2'd2;
    localparam logic [1:0] CFG_CHR_BASE = 2'd3;

    localparam logic [15:0] PRG_MASK_RST = 16'h0FFF;
    localparam logic [15:0] PRG_BASE_RST = 16'h0000;
    localparam logic [15:0] CHR_MASK_RST = 16'h7FFF;
    localparam logic [15:0] CHR_BASE_RST = 16'h0000;

    // cpu-side register file indexes
    localparam logic [7:0] CREG_OUTER      = 8'h00;
    localparam logic [7:0] CREG_IRQ_LATCH  = 8'h01;
    localparam logic [7:0] CREG_IRQ_RELOAD = 8'h02;
    localparam logic [7:0] CREG_IRQ_DIS    = 8'h03;
    localparam logic [7:0] CREG_IRQ_EN     = 8'h04;
    localparam logic [7:0] CREG_BANK_SEL   = 8'h05;
    localparam logic [7:0] CREG_MIRROR     = 8'h06;
    localparam logic [7:0] CREG_PRG0       = 8'h07;
    localparam logic [7:0] CREG_PRG1       = 8'h08;
    localparam logic [7:0] CREG_PRG2       = 8'h09;
    localparam logic [7:0] CREG_PRG_BLK    = 8'h0A;
    localparam logic [7:0] CREG_PRG_MODE   = 8'h0B;
    localparam logic [7:0] CREG_SPARE      = 8'h0F;

    // ppu-side register file indexes
    localparam logic [7:0] PREG_SEL_BASE  = 8'h10;
    localparam logic [7:0] PREG_CHR2      = 8'h12;
    localparam logic [7:0] PREG_CHR3      = 8'h13;
    localparam logic [7:0] PREG_CHR4      = 8'h14;
    localparam logic [7:0] PREG_CHR5      = 8'h15;
    localparam logic [7:0] PREG_CHR0      = 8'h16;
    localparam logic [7:0] PREG_CHR1      = 8'h17;
    localparam logic [7:0] PREG_CHR_OUTER = 8'h18;
    localparam logic [7:0] PREG_CHR_MODE  = 8'h1A;

    // MMC3-style write decode on addr & SEL_MASK
    localparam logic [15:0] MMC_SEL_MASK   = 16'hE001;
    localparam logic [15:0] MMC_BANK_SEL   = 16'h8000;
    localparam logic [15:0] MMC_BANK_DATA  = 16'h8001;
    localparam logic [15:0] MMC_MIRROR     = 16'hA000;
    localparam logic [15:0] MMC_IRQ_LATCH  = 16'hC000;
    localparam logic [15:0] MMC_IRQ_RELOAD = 16'hC001;
    localparam logic [15:0] MMC_IRQ_DIS    = 16'hE000;
    localparam logic [15:0] MMC_IRQ_EN     = 16'hE001;
    localparam logic [7:0]  BANK_SEL_WMASK = 8'hDF;

    // address windows
    localparam logic [15:0] CPU_REG_LO   = 16'h4100;
    localparam logic [15:0] CPU_REG_HI   = 16'h41FF;
    localparam logic [15:0] PPU_REG_LO   = 16'h2010;
    localparam logic [15:0] PPU_REG_HI   = 16'h20FF;
    localparam logic [15:0] RD_LO        = 16'h4100;
    localparam logic [15:0] RD_HI        = 16'h4FFF;
    localparam logic [15:0] RD_ID        = 16'h415C;
    localparam logic [15:0] RD_FF_LO     = 16'h4140;
    localparam logic [15:0] RD_FF_HI     = 16'h415F;
    localparam logic [15:0] RD_STAT_A    = 16'h418A;
    localparam logic [15:0] RD_STAT_B    = 16'h41B7;
    localparam logic [15:0] RD_STAT_C    = 16'h41B9;
    localparam logic [15:0] RD_REG_LO_HI = 16'h410D;
    localparam logic [15:0] RD_REG_LO    = 16'h4160;
    localparam logic [15:0] RD_REG_END   = 16'h4800;
    localparam logic [7:0]  RD_ID_VAL    = 8'h10;
    localparam logic [7:0]  RD_FF_VAL    = 8'hFF;
    localparam logic [7:0]  RD_STAT_VAL  = 8'h04;
    localparam logic [7:0]  RD_STAT_C_VAL = 8'h80;

    // registers that feed the bank mapping, kept in flops
    typedef struct packed {
        logic [7:0] outer;
        logic [7:0] bank_sel;
        logic [7:0] mirror;
        logic [7:0] prg0;
        logic [7:0] prg1;
        logic [7:0] prg2;
        logic [7:0] prg_blk;
        logic [7:0] prg_mode;
        logic [7:0] chr0;
        logic [7:0] chr1;
        logic [7:0] chr2;
        logic [7:0] chr3;
        logic [7:0] chr4;
        logic [7:0] chr5;
        logic [7:0] chr_outer;
        logic [7:0] chr_mode;
    } map_regs_t;

    localparam map_regs_t MAP_RESET = '{
        outer: 8'h00, bank_sel: 8'h00, mirror: 8'h00, prg0: 8'h00,
        prg1: 8'h01, prg2: 8'hFE, prg_blk: 8'h00, prg_mode: 8'h00,
        chr0: 8'h00, chr1: 8'h02, chr2: 8'h04, chr3: 8'h05,
        chr4: 8'h06, chr5: 8'h07, chr_outer: 8'h00, chr_mode: 8'h00
    };

    typedef struct packed {
        logic [15:0] prg_mask;
        logic [15:0] prg_base;
        logic [15:0] chr_mask;
        logic [15:0] chr_base;
    } cfg_t;

    // decode and status of the item at the head of the input register
    typedef struct packed {
        logic       remap;
        logic       irq_after;
        logic [7:0] read_data;
        logic       read_hit;
    } item_stat_t;

    function automatic logic [7:0] cpu_reset_val(input logic [7:0] idx);
        logic [7:0] v;
        case (idx)
            CREG_PRG1:  v = 8'h01;
            CREG_PRG2:  v = 8'hFE;
            CREG_SPARE: v = 8'hFF;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

    // pattern bank mask shift per mode
    function automatic logic [2:0] chr_shift(input logic [2:0] mode);
        logic [2:0] s;
        case (mode)
            3'd0:    s = 3'd0;
            3'd1:    s = 3'd1;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd0;
            3'd4:    s = 3'd3;
            3'd5:    s = 3'd4;
            3'd6:    s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/cbm_ram.sv]
// ----------------------------------------------------------------------------
// cbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/cbm_state.sv]
// ----------------------------------------------------------------------------
// cbm_state
// Write decode, register files, scanline counter and read answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_state
    import cbm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       acc_addr_lo,
    input  wire logic             exec,
    input  wire logic [1:0]       in_cmd,
    input  wire logic [15:0]      in_addr,
    input  wire logic [7:0]       in_data,
    output map_regs_t             map,
    output logic                  irq_pending,
    output item_stat_t            stat
);

    map_regs_t  map_reg, map_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       reload_reg, reload_next;
    logic       en_reg, en_next;
    logic       pend_reg, pend_next;
    logic [REG_DEPTH-1:0] valid_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    logic       cpu_we, ppu_we;
    logic [7:0] widx, wdata;
    logic [2:0] sel;
    logic [7:0] ram_rdata, reg_rd;
    logic       reloading;
    logic [7:0] cnt_new;
    logic [7:0] rd_data;
    logic       rd_hit;

    assign sel = map_reg.bank_sel[2:0];

    // write decode
    always_comb begin
        cpu_we = 1'b0;
        ppu_we = 1'b0;
        widx   = in_addr[7:0];
        wdata  = in_data;
        if (in_cmd == CMD_WRITE) begin
            if (in_addr >= CPU_REG_LO && in_addr <= CPU_REG_HI) begin
                cpu_we = 1'b1;
            end else if (in_addr >= PPU_REG_LO && in_addr <= PPU_REG_HI) begin
                ppu_we = 1'b1;
            end else if (in_addr[15]) begin
                case (in_addr & MMC_SEL_MASK)
                    MMC_BANK_SEL: begin
                        cpu_we = 1'b1;
                        widx   = CREG_BANK_SEL;
                        wdata  = in_data & BANK_SEL_WMASK;
                    end
                    MMC_BANK_DATA: begin
                        if (sel <= 3'd1) begin
                            ppu_we = 1'b1;
                            widx   = PREG_CHR0 + {5'b0, sel};
                        end else if (sel <= 3'd5) begin
                            ppu_we = 1'b1;
                            widx   = PREG_SEL_BASE + {5'b0, sel};
                        end else begin
                            cpu_we = 1'b1;
                            widx   = CREG_IRQ_LATCH + {5'b0, sel};
                        end
                    end
                    MMC_MIRROR: begin
                        cpu_we = 1'b1;
                        widx   = CREG_MIRROR;
                    end
                    MMC_IRQ_LATCH: begin
                        cpu_we = 1'b1;
                        widx   = CREG_IRQ_LATCH;
                    end
                    MMC_IRQ_RELOAD: begin
                        cpu_we = 1'b1;
                        widx   = CREG_IRQ_RELOAD;
                    end
                    MMC_IRQ_DIS: begin
                        cpu_we = 1'b1;
                        widx   = CREG_IRQ_DIS;
                    end
                    MMC_IRQ_EN: begin
                        cpu_we = 1'b1;
                        widx   = CREG_IRQ_EN;
                    end
                    default: begin
                        cpu_we = 1'b0;
                    end
                endcase
            end
        end
    end

    // shadow flops and scanline counter
    always_comb begin
        map_next    = map_reg;
        latch_next  = latch_reg;
        cnt_next    = cnt_reg;
        reload_next = reload_reg;
        en_next     = en_reg;
        pend_next   = pend_reg;
        reloading   = (cnt_reg == 8'd0) || reload_reg;
        cnt_new     = reloading ? latch_reg : cnt_reg - 8'd1;
        if (exec && cpu_we) begin
            case (widx)
                CREG_OUTER:      map_next.outer    = wdata;
                CREG_IRQ_LATCH:  latch_next        = wdata;
                CREG_IRQ_RELOAD: reload_next       = 1'b1;
                CREG_IRQ_DIS: begin
                    en_next   = 1'b0;
                    pend_next = 1'b0;
                end
                CREG_IRQ_EN:     en_next           = 1'b1;
                CREG_BANK_SEL:   map_next.bank_sel = wdata;
                CREG_MIRROR:     map_next.mirror   = wdata;
                CREG_PRG0:       map_next.prg0     = wdata;
                CREG_PRG1:       map_next.prg1     = wdata;
                CREG_PRG2:       map_next.prg2     = wdata;
                CREG_PRG_BLK:    map_next.prg_blk  = wdata;
                CREG_PRG_MODE:   map_next.prg_mode = wdata;
                default:         map_next          = map_reg;
            endcase
        end
        if (exec && ppu_we) begin
            case (widx)
                PREG_CHR0:      map_next.chr0      = wdata;
                PREG_CHR1:      map_next.chr1      = wdata;
                PREG_CHR2:      map_next.chr2      = wdata;
                PREG_CHR3:      map_next.chr3      = wdata;
                PREG_CHR4:      map_next.chr4      = wdata;
                PREG_CHR5:      map_next.chr5      = wdata;
                PREG_CHR_OUTER: map_next.chr_outer = wdata;
                PREG_CHR_MODE:  map_next.chr_mode  = wdata;
                default:        map_next           = map_reg;
            endcase
        end
        if (exec && in_cmd == CMD_TICK) begin
            cnt_next    = cnt_new;
            reload_next = reloading ? 1'b0 : reload_reg;
            if (cnt_reg != 8'd0 && cnt_new == 8'd0 && en_reg) begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg      <= MAP_RESET;
            latch_reg    <= 8'd0;
            cnt_reg      <= 8'd0;
            reload_reg   <= 1'b0;
            en_reg       <= 1'b0;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            map_reg    <= map_next;
            latch_reg  <= latch_next;
            cnt_reg    <= cnt_next;
            reload_reg <= reload_next;
            en_reg     <= en_next;
            pend_reg   <= pend_next;
            if (exec && cpu_we) begin
                valid_reg[widx] <= 1'b1;
            end
            // a read issued at the same edge as a write to its entry gets the written data forwarded
            if (accept) begin
                fwd_hit_reg <= exec && cpu_we && (widx == acc_addr_lo);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= wdata;
        end
    end

    // full cpu register file, read for bus reads
    cbm_ram #(
        .WIDTH (8),
        .DEPTH (REG_DEPTH)
    ) u_cpu_ram (
        .aclk  (aclk),
        .we    (exec && cpu_we),
        .waddr (widx),
        .wdata (wdata),
        .re    (accept),
        .raddr (acc_addr_lo),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (fwd_hit_reg) begin
            reg_rd = fwd_data_reg;
        end else if (valid_reg[in_addr[7:0]]) begin
            reg_rd = ram_rdata;
        end else begin
            reg_rd = cpu_reset_val(in_addr[7:0]);
        end
    end

    always_comb begin
        rd_hit  = 1'b0;
        rd_data = 8'd0;
        if (in_cmd == CMD_READ && in_addr >= RD_LO && in_addr <= RD_HI) begin
            rd_hit = 1'b1;
            if (in_addr == RD_ID) begin
                rd_data = RD_ID_VAL;
            end else if (in_addr >= RD_FF_LO && in_addr <= RD_FF_HI) begin
                rd_data = RD_FF_VAL;
            end else if (in_addr == RD_STAT_A || in_addr == RD_STAT_B) begin
                rd_data = RD_STAT_VAL;
            end else if (in_addr == RD_STAT_C) begin
                rd_data = RD_STAT_C_VAL;
            end else if (in_addr <= RD_REG_LO_HI
                         || (in_addr >= RD_REG_LO && in_addr < RD_REG_END)) begin
                rd_data = reg_rd;
            end else begin
                rd_hit = 1'b0;
            end
        end
    end

    assign map            = map_reg;
    assign irq_pending    = pend_reg;
    assign stat.remap     = cpu_we || ppu_we;
    assign stat.irq_after = pend_next;
    assign stat.read_data = rd_data;
    assign stat.read_hit  = rd_hit;

endmodule

`default_nettype wire

[rtl/cbm_slot.sv]
// ----------------------------------------------------------------------------
// cbm_slot
// Window address and bank number of one program or pattern slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_slot
    import cbm_pkg::*;
(
    input  wire logic [SLOT_W-1:0] idx,
    input  map_regs_t              map,
    input  cfg_t                   cfg,
    output kind_t                  kind,
    output logic [15:0]            window_addr,
    output logic [15:0]            bank_number,
    output logic                   last
);

    localparam logic [SLOT_W-1:0] PRG_N   = SLOT_W'(PRG_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_ID = SLOT_W'(SLOT_COUNT - 1);

    logic [2:0]  mode;
    logic [7:0]  pm, pb;
    logic [11:0] pblk;
    logic [1:0]  prg_i;
    logic [15:0] pwin, pbank;
    logic [2:0]  chr_i;
    logic [SLOT_W-1:0] chr_off;
    logic [7:0]  cm, cb;
    logic [15:0] cblk, cwin, cbank;

    // program side
    assign mode  = map.prg_mode[2:0];
    assign pm    = (mode == 3'd7) ? 8'hFF : (8'h3F >> mode);
    assign pblk  = {map.outer[7:4], map.prg_blk & ~pm};
    assign prg_i = idx[1:0];

    always_comb begin
        case (prg_i)
            2'd0:    pb = map.prg0;
            2'd1:    pb = map.prg1;
            2'd2:    pb = map.prg_mode[6] ? map.prg2 : 8'hFE;
            default: pb = 8'hFF;
        endcase
    end

    // even slots swap with bit 6 of bank select
    assign pwin  = {1'b1, prg_i, 13'd0}
                 ^ (prg_i[0] ? 16'd0 : {1'b0, map.bank_sel[6], 14'd0});
    assign pbank = cfg.prg_base | ({4'd0, pblk | {4'd0, pb & pm}} & cfg.prg_mask);

    // pattern side
    assign chr_off = idx - PRG_N;
    assign chr_i   = chr_off[2:0];
    assign cm      = 8'hFF >> chr_shift(map.chr_mode[2:0]);
    assign cblk    = {1'b0, map.outer[3:0], map.chr_outer[6:4], map.chr_mode & ~cm};

    always_comb begin
        case (chr_i)
            3'd0:    cb = map.chr0 & 8'hFE;
            3'd1:    cb = map.chr0 | 8'h01;
            3'd2:    cb = map.chr1 & 8'hFE;
            3'd3:    cb = map.chr1 | 8'h01;
            3'd4:    cb = map.chr2;
            3'd5:    cb = map.chr3;
            3'd6:    cb = map.chr4;
            default: cb = map.chr5;
        endcase
    end

    assign cwin  = {3'd0, chr_i, 10'd0} ^ {3'd0, map.bank_sel[7], 12'd0};
    assign cbank = cfg.chr_base | ((cblk | {8'd0, cb & cm}) & cfg.chr_mask);

    always_comb begin
        if (idx < PRG_N) begin
            kind        = KIND_PRG;
            window_addr = pwin;
            bank_number = pbank;
        end else begin
            kind        = KIND_CHR;
            window_addr = cwin;
            bank_number = cbank;
        end
    end

    assign last = (idx == LAST_ID);

endmodule

`default_nettype wire

[rtl/console_bank_mapper_irq.sv]
// ----------------------------------------------------------------------------
// console_bank_mapper_irq
// Path: an accepted item waits in the input word register; a read, tick or ignored
// write then loads one status word into the output word register, while a remap write
// starts the slot sequencer: 12 slots, one output slot per cycle unless the output stalls.
// Reset: synchronous; clears control, irq state, config and valid bits at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "console_bank_mapper_irq_macros.svh"

module console_bank_mapper_irq
    import cbm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // item input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [15:0] s_bus_addr,
    input  wire logic [7:0]  s_bus_data,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_window_addr,
    output logic [15:0]      m_bank_number,
    output logic             m_mirror_mode,
    output logic             m_irq_line,
    output logic [7:0]       m_read_data,
    output logic             m_read_hit,
    output logic             m_last,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        seq_busy_reg;
    logic [SLOT_W-1:0] seq_idx_reg;

    logic        m_valid_reg;
    kind_t       m_kind_reg;
    logic [15:0] m_window_reg, m_bank_reg;
    logic        m_mirror_reg, m_irq_reg, m_hit_reg, m_last_reg;
    logic [7:0]  m_rdata_reg;

    map_regs_t   map;
    logic        irq_pending;
    item_stat_t  st;
    kind_t       slot_kind;
    logic [15:0] slot_window, slot_bank;
    logic        slot_last;

    logic        accept, exec, out_free, seq_emit, seq_last;

    assign out_free = !m_valid_reg || m_ready;
    assign seq_emit = seq_busy_reg && out_free;
    assign seq_last = (seq_idx_reg == LAST_IDX);
    // a remap may start while the previous one hands out its final slot
    assign exec     = in_valid_reg && (st.remap
                    ? (!seq_busy_reg || (seq_emit && seq_last))
                    : (!seq_busy_reg && out_free));
    assign s_ready  = !in_valid_reg || exec;
    assign accept   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{prg_mask: PRG_MASK_RST, prg_base: PRG_BASE_RST,
                         chr_mask: CHR_MASK_RST, chr_base: CHR_BASE_RST};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PRG_MASK: cfg_reg.prg_mask <= cfg_data;
                CFG_PRG_BASE: cfg_reg.prg_base <= cfg_data;
                CFG_CHR_MASK: cfg_reg.chr_mask <= cfg_data;
                CFG_CHR_BASE: cfg_reg.chr_base <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (exec) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_cmd_reg  <= s_cmd;
            in_addr_reg <= s_bus_addr;
            in_data_reg <= s_bus_data;
        end
    end

    cbm_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .acc_addr_lo (s_bus_addr[7:0]),
        .exec        (exec),
        .in_cmd      (in_cmd_reg),
        .in_addr     (in_addr_reg),
        .in_data     (in_data_reg),
        .map         (map),
        .irq_pending (irq_pending),
        .stat        (st)
    );

    cbm_slot u_slot (
        .idx         (seq_idx_reg),
        .map         (map),
        .cfg         (cfg_reg),
        .kind        (slot_kind),
        .window_addr (slot_window),
        .bank_number (slot_bank),
        .last        (slot_last)
    );

    // slot sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_busy_reg <= 1'b0;
            seq_idx_reg  <= '0;
        end else if (exec && st.remap) begin
            seq_busy_reg <= 1'b1;
            seq_idx_reg  <= '0;
        end else if (seq_emit) begin
            if (seq_last) begin
                seq_busy_reg <= 1'b0;
            end else begin
                seq_idx_reg <= seq_idx_reg + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_emit || (exec && !st.remap)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_emit) begin
            m_kind_reg   <= slot_kind;
            m_window_reg <= slot_window;
            m_bank_reg   <= slot_bank;
            m_mirror_reg <= ~map.mirror[0];
            m_irq_reg    <= irq_pending;
            m_rdata_reg  <= 8'd0;
            m_hit_reg    <= 1'b0;
            m_last_reg   <= slot_last;
        end else if (exec && !st.remap) begin
            m_kind_reg   <= KIND_STATUS;
            m_window_reg <= 16'd0;
            m_bank_reg   <= 16'd0;
            m_mirror_reg <= ~map.mirror[0];
            m_irq_reg    <= st.irq_after;
            m_rdata_reg  <= st.read_data;
            m_hit_reg    <= st.read_hit;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_window_addr = m_window_reg;
    assign m_bank_number = m_bank_reg;
    assign m_mirror_mode = m_mirror_reg;
    assign m_irq_line    = m_irq_reg;
    assign m_read_data   = m_rdata_reg;
    assign m_read_hit    = m_hit_reg;
    assign m_last        = m_last_reg;

    `CBM_ASSERT_NOW(a_status_when_idle, aclk, aresetn, exec && !st.remap, !seq_busy_reg && out_free, "status word issued while slots pending")
    `CBM_ASSERT_NEXT(a_remap_starts, aclk, aresetn, exec && st.remap, seq_busy_reg && seq_idx_reg == '0, "remap did not start at first slot")
    `CBM_ASSERT_NEXT(a_last_on_final, aclk, aresetn, seq_emit, m_valid_reg && (m_last_reg == $past(seq_last)), "last flag off the final slot")
    `CBM_ASSERT_NOW(a_idx_range, aclk, aresetn, seq_busy_reg, seq_idx_reg <= LAST_IDX, "slot index out of range")

endmodule

`default_nettype wire

[tb/bank_map_checker.sv]
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the bus item, result and configuration channels of the bank mapper.
// Keeps its own copy of the register files, interrupt counter and bank masks,
// predicts the result words of every accepted item and compares each accepted
// result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_map_checker
    import cbm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [15:0] s_bus_addr,
    input  wire logic [7:0]  s_bus_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_kind,
    input  wire logic [15:0] m_window_addr,
    input  wire logic [15:0] m_bank_number,
    input  wire logic        m_mirror_mode,
    input  wire logic        m_irq_line,
    input  wire logic [7:0]  m_read_data,
    input  wire logic        m_read_hit,
    input  wire logic        m_last,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               err_count,
    output int               pending,
    output int               words_checked,
    output int               irq_words,
    output int               remap_count
);

    typedef struct packed {
        kind_t       kind;
        logic [15:0] window;
        logic [15:0] bank;
        logic        mirror;
        logic        irq;
        logic [7:0]  rdata;
        logic        hit;
        logic        last;
    } slot_word_t;

    // pattern mask shift per mode, mode 0 in the low bits
    localparam logic [23:0] CHR_SHIFTS = {3'd0, 3'd5, 3'd4, 3'd3, 3'd0, 3'd2, 3'd1, 3'd0};

    slot_word_t  expected_slots[$];
    logic [7:0]  cpu_file[256];
    logic [7:0]  ppu_file[256];
    logic [7:0]  scan_count;
    logic        reload_pend;
    logic        irq_armed;
    logic        irq_flag;
    cfg_t        map_cfg;

    task automatic reset_model();
        for (int i = 0; i < 256; i++) begin
            cpu_file[i] = 8'h00;
            ppu_file[i] = 8'h00;
        end
        cpu_file[CREG_PRG1]  = 8'h01;
        cpu_file[CREG_PRG2]  = 8'hFE;
        cpu_file[CREG_SPARE] = 8'hFF;
        ppu_file[PREG_CHR2]  = 8'h04;
        ppu_file[PREG_CHR3]  = 8'h05;
        ppu_file[PREG_CHR4]  = 8'h06;
        ppu_file[PREG_CHR5]  = 8'h07;
        ppu_file[PREG_CHR1]  = 8'h02;
        scan_count  = 8'h00;
        reload_pend = 1'b0;
        irq_armed   = 1'b0;
        irq_flag    = 1'b0;
        map_cfg.prg_mask = PRG_MASK_RST;
        map_cfg.prg_base = PRG_BASE_RST;
        map_cfg.chr_mask = CHR_MASK_RST;
        map_cfg.chr_base = CHR_BASE_RST;
    endtask

    // mirror and irq reflect the state after the item
    task automatic push_word(input kind_t k, input logic [15:0] win, input logic [15:0] bank,
                             input logic [7:0] rd, input logic hit, input logic lst);
        slot_word_t w;
        w.kind   = k;
        w.window = win;
        w.bank   = bank;
        w.mirror = ~cpu_file[CREG_MIRROR][0];
        w.irq    = irq_flag;
        w.rdata  = rd;
        w.hit    = hit;
        w.last   = lst;
        expected_slots.push_back(w);
    endtask

    task automatic write_cpu_reg(input logic [7:0] idx, input logic [7:0] v);
        if (idx == CREG_IRQ_RELOAD) begin
            reload_pend = 1'b1;
        end else if (idx == CREG_IRQ_DIS) begin
            irq_flag  = 1'b0;
            irq_armed = 1'b0;
        end else if (idx == CREG_IRQ_EN) begin
            irq_armed = 1'b1;
        end
        cpu_file[idx] = v;
    endtask

    task automatic push_remap();
        logic [2:0]  mode;
        logic [7:0]  pm;
        logic [7:0]  cm;
        logic [15:0] pblk;
        logic [15:0] cblk;
        logic [15:0] psw;
        logic [15:0] csw;
        logic [15:0] win;
        logic [15:0] bank;
        logic [7:0]  pb[4];
        logic [7:0]  cb[8];
        mode = cpu_file[CREG_PRG_MODE][2:0];
        pm   = (mode == 3'd7) ? 8'hFF : (8'h3F >> mode);
        pblk = {4'h0, cpu_file[CREG_OUTER][7:4], 8'h00} | {8'h00, cpu_file[CREG_PRG_BLK] & ~pm};
        psw  = {1'b0, cpu_file[CREG_BANK_SEL][6], 14'h0000};
        pb[0] = cpu_file[CREG_PRG0];
        pb[1] = cpu_file[CREG_PRG1];
        pb[2] = cpu_file[CREG_PRG_MODE][6] ? cpu_file[CREG_PRG2] : 8'hFE;
        pb[3] = 8'hFF;
        for (int i = 0; i < 4; i++) begin
            win = 16'h8000 + 16'h2000 * i;
            if (i == 0 || i == 2) win = win ^ psw;
            bank = map_cfg.prg_base | ((pblk | {8'h00, pb[i] & pm}) & map_cfg.prg_mask);
            push_word(KIND_PRG, win, bank, 8'h00, 1'b0, 1'b0);
        end

        cm   = 8'hFF >> CHR_SHIFTS[3 * ppu_file[PREG_CHR_MODE][2:0] +: 3];
        cblk = {1'b0, cpu_file[CREG_OUTER][3:0], 11'h000}
             | {5'h00, ppu_file[PREG_CHR_OUTER][6:4], 8'h00}
             | {8'h00, ppu_file[PREG_CHR_MODE] & ~cm};
        csw  = {3'b000, cpu_file[CREG_BANK_SEL][7], 12'h000};
        cb[0] = ppu_file[PREG_CHR0] & 8'hFE;
        cb[1] = ppu_file[PREG_CHR0] | 8'h01;
        cb[2] = ppu_file[PREG_CHR1] & 8'hFE;
        cb[3] = ppu_file[PREG_CHR1] | 8'h01;
        cb[4] = ppu_file[PREG_CHR2];
        cb[5] = ppu_file[PREG_CHR3];
        cb[6] = ppu_file[PREG_CHR4];
        cb[7] = ppu_file[PREG_CHR5];
        for (int i = 0; i < 8; i++) begin
            win  = (16'h0400 * i) ^ csw;
            bank = map_cfg.chr_base | ((cblk | {8'h00, cb[i] & cm}) & map_cfg.chr_mask);
            push_word(KIND_CHR, win, bank, 8'h00, 1'b0, i == 7);
        end
    endtask

    task automatic predict_bus_item(input logic [1:0] c, input logic [15:0] a,
                                    input logic [7:0] d);
        logic [7:0] old;
        logic [7:0] rd;
        logic       hit;
        logic [2:0] sel;
        logic       remap_now;
        case (c)
            CMD_WRITE: begin
                remap_now = 1'b1;
                if (a >= CPU_REG_LO && a <= CPU_REG_HI) begin
                    write_cpu_reg(a[7:0], d);
                end else if (a >= PPU_REG_LO && a <= PPU_REG_HI) begin
                    ppu_file[a[7:0]] = d;
                end else if (a[15]) begin
                    case (a & MMC_SEL_MASK)
                        MMC_BANK_SEL:   write_cpu_reg(CREG_BANK_SEL, d & BANK_SEL_WMASK);
                        MMC_BANK_DATA: begin
                            sel = cpu_file[CREG_BANK_SEL][2:0];
                            if (sel <= 1)
                                ppu_file[PREG_CHR0 + sel] = d;
                            else if (sel <= 5)
                                ppu_file[PREG_SEL_BASE + sel] = d;
                            else
                                write_cpu_reg(CREG_IRQ_LATCH + sel, d);
                        end
                        MMC_MIRROR:     write_cpu_reg(CREG_MIRROR, d);
                        MMC_IRQ_LATCH:  write_cpu_reg(CREG_IRQ_LATCH, d);
                        MMC_IRQ_RELOAD: write_cpu_reg(CREG_IRQ_RELOAD, d);
                        MMC_IRQ_DIS:    write_cpu_reg(CREG_IRQ_DIS, d);
                        MMC_IRQ_EN:     write_cpu_reg(CREG_IRQ_EN, d);
                        default:        remap_now = 1'b0;
                    endcase
                end else begin
                    remap_now = 1'b0;
                end
                if (remap_now) begin
                    push_remap();
                    remap_count++;
                end else begin
                    push_word(KIND_STATUS, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1);
                end
            end
            CMD_READ: begin
                rd  = 8'h00;
                hit = 1'b0;
                if (a >= RD_LO && a <= RD_HI) begin
                    hit = 1'b1;
                    if (a == RD_ID)
                        rd = RD_ID_VAL;
                    else if (a >= RD_FF_LO && a <= RD_FF_HI)
                        rd = RD_FF_VAL;
                    else if (a == RD_STAT_A || a == RD_STAT_B)
                        rd = RD_STAT_VAL;
                    else if (a == RD_STAT_C)
                        rd = RD_STAT_C_VAL;
                    else if (a <= RD_REG_LO_HI || (a >= RD_REG_LO && a < RD_REG_END))
                        rd = cpu_file[a[7:0]];
                    else
                        hit = 1'b0;
                end
                push_word(KIND_STATUS, 16'h0000, 16'h0000, rd, hit, 1'b1);
            end
            CMD_TICK: begin
                old = scan_count;
                if (old == 8'h00 || reload_pend) begin
                    scan_count  = cpu_file[CREG_IRQ_LATCH];
                    reload_pend = 1'b0;
                end else begin
                    scan_count = old - 8'h01;
                end
                if (old != 8'h00 && scan_count == 8'h00 && irq_armed) irq_flag = 1'b1;
                push_word(KIND_STATUS, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1);
            end
            default: push_word(KIND_STATUS, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1);
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: word %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, words_checked, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        slot_word_t w;
        if (!aresetn) begin
            reset_model();
            expected_slots.delete();
            err_count     = 0;
            words_checked = 0;
            irq_words     = 0;
            remap_count   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PRG_MASK: map_cfg.prg_mask = cfg_data;
                    CFG_PRG_BASE: map_cfg.prg_base = cfg_data;
                    CFG_CHR_MASK: map_cfg.chr_mask = cfg_data;
                    CFG_CHR_BASE: map_cfg.chr_base = cfg_data;
                endcase
            end
            // compare before predicting: a word never belongs to an item accepted this edge
            if (m_valid && m_ready) begin
                if (expected_slots.size() == 0) begin
                    $display("%0t: result word with none expected, kind 0x%0h window 0x%0h",
                             $time, m_kind, m_window_addr);
                    err_count++;
                end else begin
                    w = expected_slots.pop_front();
                    check_field("kind",        w.kind,   m_kind);
                    check_field("window_addr", w.window, m_window_addr);
                    check_field("bank_number", w.bank,   m_bank_number);
                    check_field("mirror_mode", w.mirror, m_mirror_mode);
                    check_field("irq_line",    w.irq,    m_irq_line);
                    check_field("read_data",   w.rdata,  m_read_data);
                    check_field("read_hit",    w.hit,    m_read_hit);
                    check_field("last",        w.last,   m_last);
                end
                words_checked++;
                if (m_irq_line) irq_words++;
            end
            if (s_valid && s_ready) predict_bus_item(s_cmd, s_bus_addr, s_bus_data);
        end
        pending = expected_slots.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bank mapper: a directed pass over the decode windows, the
// read map and the scanline interrupt, then random bus traffic in phases with
// different mapping masks, sender gaps and receiver stalls, and a long output
// hold that backs the block up. Checking is done by bank_map_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import cbm_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS = 55;
    localparam int         TIMEOUT_NS  = 5_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [15:0] s_bus_addr;
    logic [7:0]  s_bus_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [15:0] m_window_addr;
    logic [15:0] m_bank_number;
    logic        m_mirror_mode;
    logic        m_irq_line;
    logic [7:0]  m_read_data;
    logic        m_read_hit;
    logic        m_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int err_count;
    int pending_words;
    int words_checked;
    int irq_words;
    int remap_count;

    int tx_idle_pct;
    int rx_stall_pct;
    int items_sent;
    int cfg_sets;
    bit hold_req;
    bit rx_block;

    console_bank_mapper_irq i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_bus_addr    (s_bus_addr),
        .s_bus_data    (s_bus_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_window_addr (m_window_addr),
        .m_bank_number (m_bank_number),
        .m_mirror_mode (m_mirror_mode),
        .m_irq_line    (m_irq_line),
        .m_read_data   (m_read_data),
        .m_read_hit    (m_read_hit),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bank_map_checker i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_bus_addr    (s_bus_addr),
        .s_bus_data    (s_bus_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_window_addr (m_window_addr),
        .m_bank_number (m_bank_number),
        .m_mirror_mode (m_mirror_mode),
        .m_irq_line    (m_irq_line),
        .m_read_data   (m_read_data),
        .m_read_hit    (m_read_hit),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .err_count     (err_count),
        .pending       (pending_words),
        .words_checked (words_checked),
        .irq_words     (irq_words),
        .remap_count   (remap_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= !rx_block && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long output hold, counted here while the sender keeps offering words
    initial begin
        rx_block = 1'b0;
        wait (hold_req);
        @(posedge aclk);
        rx_block = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_block = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d result words outstanding", pending_words);
        $display("TEST FAILED");
        $finish;
    end

    // entered and left just after a falling edge; valid stays up when no gap follows
    task automatic send_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= c;
        s_bus_addr <= a;
        s_bus_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_map_cfg(input logic [15:0] pm, input logic [15:0] pb,
                               input logic [15:0] cm, input logic [15:0] cb);
        drain();
        cfg_write(CFG_PRG_MASK, pm);
        cfg_write(CFG_PRG_BASE, pb);
        cfg_write(CFG_CHR_MASK, cm);
        cfg_write(CFG_CHR_BASE, cb);
        cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    task automatic directed_items();
        send_item(CMD_READ, RD_ID, 8'h00);
        send_item(CMD_READ, RD_FF_HI, 8'h00);
        send_item(CMD_READ, RD_STAT_A, 8'h00);
        send_item(CMD_READ, RD_STAT_B, 8'h00);
        send_item(CMD_READ, RD_STAT_C, 8'h00);
        send_item(CMD_READ, RD_REG_LO_HI, 8'h00);
        send_item(CMD_READ, RD_REG_LO_HI + 16'h1, 8'h00);
        send_item(CMD_READ, RD_REG_END - 16'h1, 8'h00);
        send_item(CMD_READ, RD_REG_END, 8'h00);
        send_item(CMD_READ, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, MMC_BANK_SEL, 8'hFF);
        send_item(CMD_WRITE, MMC_BANK_DATA, 8'hFF);
        send_item(CMD_WRITE, MMC_MIRROR, 8'h01);
        // odd address in the mirror window decodes to nothing
        send_item(CMD_WRITE, MMC_MIRROR | 16'h0001, 8'h55);
        send_item(CMD_WRITE, MMC_IRQ_LATCH, 8'h02);
        send_item(CMD_WRITE, MMC_IRQ_RELOAD, 8'h00);
        send_item(CMD_WRITE, 16'hFFFF, 8'h00);
        // reload, count down, then fire
        repeat (3) send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_WRITE, MMC_IRQ_DIS, 8'h00);
        send_item(CMD_WRITE, PPU_REG_HI, 8'hAA);
        send_item(CMD_WRITE, PPU_REG_LO | PREG_CHR_MODE, 8'h06);
        send_item(CMD_WRITE, CPU_REG_LO | CREG_PRG_MODE, 8'hC7);
        send_item(CMD_WRITE, 16'h0000, 8'h5A);
        send_item(CMD_UNUSED, 16'h1234, 8'h00);
    endtask

    task automatic random_traffic();
        int          r;
        logic [15:0] mir;
        logic [7:0]  latch;
        r   = $urandom_range(99);
        mir = $urandom_range(16'hFFFF) & 16'h1FFE;
        if (r < 25) begin
            send_item(CMD_WRITE, MMC_BANK_SEL | mir, $urandom_range(255));
            send_item(CMD_WRITE, MMC_BANK_DATA | mir, $urandom_range(255));
        end else if (r < 40) begin
            latch = (r < 28) ? $urandom_range(255) : $urandom_range(7);
            send_item(CMD_WRITE, MMC_IRQ_LATCH | mir, latch);
            send_item(CMD_WRITE, MMC_IRQ_RELOAD | mir, $urandom_range(255));
            if ($urandom_range(3) == 0)
                send_item(CMD_WRITE, MMC_IRQ_DIS | mir, $urandom_range(255));
            else
                send_item(CMD_WRITE, MMC_IRQ_EN | mir, $urandom_range(255));
            repeat ($urandom_range(9, 1)) send_item(CMD_TICK, $urandom_range(16'hFFFF),
                                                    $urandom_range(255));
            send_item(CMD_READ, CPU_REG_LO | CREG_IRQ_LATCH, 8'h00);
        end else if (r < 55) begin
            send_item(CMD_WRITE, CPU_REG_LO | ((r < 52) ? $urandom_range(15) : $urandom_range(255)),
                      $urandom_range(255));
        end else if (r < 65) begin
            send_item(CMD_WRITE, PPU_REG_LO & 16'hFF00 | ((r < 62) ? $urandom_range(8'h1A, 8'h10)
                                                                   : $urandom_range(8'hFF, 8'h10)),
                      $urandom_range(255));
        end else if (r < 78) begin
            send_item(CMD_READ, (r < 72) ? (RD_LO | $urandom_range(255))
                                         : $urandom_range(16'h4FFF, 16'h4000),
                      $urandom_range(255));
        end else if (r < 88) begin
            send_item(CMD_TICK, $urandom_range(16'hFFFF), $urandom_range(255));
        end else begin
            send_item($urandom_range(3), $urandom_range(16'hFFFF), $urandom_range(255));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int target;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) random_traffic();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_WRITE;
        s_bus_addr   = 16'h0000;
        s_bus_data   = 8'h00;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PRG_MASK;
        cfg_data     = 16'h0000;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        items_sent   = 0;
        cfg_sets     = 0;
        hold_req     = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_items();

        set_map_cfg(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        run_phase(0, 0);
        set_map_cfg(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        run_phase(60, 0);
        set_map_cfg($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        run_phase(0, 60);
        set_map_cfg($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        run_phase(9, 9);

        // back-to-back remaps into a held output
        set_map_cfg(PRG_MASK_RST, PRG_BASE_RST, CHR_MASK_RST, CHR_BASE_RST);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        repeat (30) send_item(CMD_WRITE, CPU_REG_LO | $urandom_range(15), $urandom_range(255));

        drain();
        repeat (20) @(negedge aclk);
        $display("Ran %0d bus items (%0d remapping writes) under %0d mask settings,",
                 items_sent, remap_count, cfg_sets + 1);
        $display("with gaps, stalls and a %0d-cycle hold; %0d words checked, %0d with irq high.",
                 HOLD_CYCLES, words_checked, irq_words);
        if (err_count == 0 && pending_words == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_ram.sv
rtl/cbm_state.sv
rtl/cbm_slot.sv
rtl/console_bank_mapper_irq.sv
tb/bank_map_checker.sv
tb/tb_top.sv
